/* src/wacs_pkg.sv */
// ----------------------------------------------------------------------------
// wacs_pkg: shared constants and helpers for the window address sequencer
// Display memory geometry, command byte codes, request kinds and the small
// wrap-around helpers used when the cursor moves inside the write window.
// ----------------------------------------------------------------------------
`default_nettype none

package wacs_pkg;

  // display memory geometry
  localparam int MEM_COLUMNS = 132;
  localparam int MEM_PAGES   = 8;

  // field widths
  localparam int ColW  = 8;
  localparam int PageW = 3;
  localparam int ByteW = 8;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 8;

  // command byte bases and masks
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
  localparam logic [7:0] PAGE_MASK    = 8'h07;

  // request kinds
  typedef enum logic {
    REQ_PIXEL   = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_COLUMN = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_END_COLUMN   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_START_PAGE   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_END_PAGE     = 8'd3;

  // reduce a column value below twice the memory width to below the memory width
  function automatic logic [ColW-1:0] col_mod(input logic [ColW:0] c);
    logic [ColW:0] d;
    d = c - (ColW+1)'(MEM_COLUMNS);
    if (c >= (ColW+1)'(MEM_COLUMNS)) begin
      return d[ColW-1:0];
    end
    return c[ColW-1:0];
  endfunction

  // reduce a page value below twice the page count to below the page count
  function automatic logic [PageW-1:0] page_mod(input logic [PageW:0] p);
    logic [PageW:0] d;
    d = p - (PageW+1)'(MEM_PAGES);
    if (p >= (PageW+1)'(MEM_PAGES)) begin
      return d[PageW-1:0];
    end
    return p[PageW-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/window_address_command_sequencer_top.sv */
// ----------------------------------------------------------------------------
// window_address_command_sequencer_top: window addressing for a paged display
// Turns pixel bytes and restart requests into controller command and data
// bytes, keeping a cursor that walks the write window page by page.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : requests; in_tuser is the kind (0 pixel, 1 restart), in_tdata
//           the pixel byte. A transfer happens when in_tvalid && in_tready.
//   out_* : controller bytes; out_tuser = 1 marks a command byte, out_tlast
//           marks the last byte caused by one request.
//   cfg_* : window registers (0 start column, 1 end column, 2 start page,
//           3 end page), always ready; user writes only while idle (unchecked).
// Timing and throughput
//   The first byte of a request shows on out_* the cycle after its transfer.
//   A request yields 1, 3 or 4 bytes and the output drains one byte per
//   cycle while out_tready is high; a plain pixel byte flows at one per
//   cycle when out_tready stays high. The single output byte buffer lets
//   the next request load while the last byte of the current one is taken.
// Reset
//   rst_n low clears the cursor, pending wrap and output buffer and loads
//   the window registers with 0, 131, 0 and 0.
// Stall
//   With out_tready low the current byte holds and in_tready stays low;
//   in_tready is high only with the buffer empty or its last byte taken.
// ----------------------------------------------------------------------------
`default_nettype none

module window_address_command_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] pixel_byte
  input  wire logic       in_tuser,   // [0] req_type
  // byte channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] is_command
  output logic            out_tlast,  // last_of_run
  // configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int ColW  = wacs_pkg::ColW;
  localparam int PageW = wacs_pkg::PageW;

  // window registers
  logic [ColW-1:0]  start_col_r, end_col_r;
  logic [PageW-1:0] start_page_r, end_page_r;

  // cursor state
  logic [ColW-1:0]  column_pos_r, column_pos_nxt;
  logic [PageW-1:0] page_pos_r, page_pos_nxt;
  logic             wrap_r, wrap_nxt;

  // output byte buffer
  logic             busy_r;
  logic [1:0]       idx_r, last_idx_r, last_idx_nxt;
  logic [7:0]       byte_r [4];
  logic             cmd_r  [4];
  logic [7:0]       byte_nxt [4];
  logic             cmd_nxt  [4];

  logic             in_fire, out_fire, at_last;
  logic             is_restart;
  logic [ColW-1:0]  base_col, col_inc, end_col_p1;
  logic [PageW-1:0] base_page, page_inc, end_page_p1;
  logic [7:0]       page_cmd, low_cmd, high_cmd;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign at_last    = (idx_r == last_idx_r);
  assign out_tvalid = busy_r;
  assign out_fire   = busy_r && out_tready;
  assign in_tready  = !busy_r || (out_tready && at_last);
  assign in_fire    = in_tvalid && in_tready;
  assign is_restart = (in_tuser == wacs_pkg::REQ_RESTART);

  // output fields from the buffer
  assign out_tdata = byte_r[idx_r];
  assign out_tuser = cmd_r[idx_r];
  assign out_tlast = at_last;

  // next page inside the window, wrapping back to the start page
  always_comb begin
    page_inc    = wacs_pkg::page_mod({1'b0, page_pos_r} + 4'd1);
    end_page_p1 = wacs_pkg::page_mod(
                    {1'b0, wacs_pkg::page_mod({1'b0, end_page_r})} + 4'd1);
    if (page_inc == end_page_p1) begin
      page_inc = wacs_pkg::page_mod({1'b0, start_page_r});
    end
  end

  // cursor position the request's bytes refer to
  always_comb begin
    if (is_restart || wrap_r) begin
      base_col = wacs_pkg::col_mod({1'b0, start_col_r});
    end else begin
      base_col = column_pos_r;
    end
    if (is_restart) begin
      base_page = wacs_pkg::page_mod({1'b0, start_page_r});
    end else if (wrap_r) begin
      base_page = page_inc;
    end else begin
      base_page = page_pos_r;
    end
  end

  // column step after a data byte and the wrap test
  assign col_inc    = wacs_pkg::col_mod({1'b0, base_col} + 9'd1);
  assign end_col_p1 = wacs_pkg::col_mod(
                        {1'b0, wacs_pkg::col_mod({1'b0, end_col_r})} + 9'd1);

  // positioning command bytes
  assign page_cmd = wacs_pkg::CMD_PAGE | ({5'd0, base_page} & wacs_pkg::PAGE_MASK);
  assign low_cmd  = wacs_pkg::CMD_COL_LOW | (base_col & wacs_pkg::NIBBLE_MASK);
  assign high_cmd = wacs_pkg::CMD_COL_HIGH | ({4'd0, base_col[7:4]} & wacs_pkg::NIBBLE_MASK);

  // buffer contents and next cursor for an accepted request
  always_comb begin
    byte_nxt[0] = page_cmd;
    byte_nxt[1] = low_cmd;
    byte_nxt[2] = high_cmd;
    byte_nxt[3] = in_tdata;
    cmd_nxt[0]  = 1'b1;
    cmd_nxt[1]  = 1'b1;
    cmd_nxt[2]  = 1'b1;
    cmd_nxt[3]  = 1'b0;
    last_idx_nxt   = 2'd3;
    column_pos_nxt = col_inc;
    page_pos_nxt   = base_page;
    wrap_nxt       = (col_inc == end_col_p1);
    if (is_restart) begin
      last_idx_nxt   = 2'd2;
      column_pos_nxt = base_col;
      wrap_nxt       = 1'b0;
    end else if (!wrap_r) begin
      // plain data byte only
      byte_nxt[0]  = in_tdata;
      cmd_nxt[0]   = 1'b0;
      last_idx_nxt = 2'd0;
    end
  end

  // control, cursor and window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      idx_r        <= 2'd0;
      last_idx_r   <= 2'd0;
      column_pos_r <= '0;
      page_pos_r   <= '0;
      wrap_r       <= 1'b0;
      start_col_r  <= 8'd0;
      end_col_r    <= 8'd131;
      start_page_r <= 3'd0;
      end_page_r   <= 3'd0;
    end else begin
      if (in_fire) begin
        busy_r       <= 1'b1;
        idx_r        <= 2'd0;
        last_idx_r   <= last_idx_nxt;
        column_pos_r <= column_pos_nxt;
        page_pos_r   <= page_pos_nxt;
        wrap_r       <= wrap_nxt;
      end else if (out_fire) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wacs_pkg::REG_START_COLUMN: start_col_r  <= cfg_data;
          wacs_pkg::REG_END_COLUMN:   end_col_r    <= cfg_data;
          wacs_pkg::REG_START_PAGE:   start_page_r <= cfg_data[PageW-1:0];
          wacs_pkg::REG_END_PAGE:     end_page_r   <= cfg_data[PageW-1:0];
          default: ;
        endcase
      end
    end
  end

  // byte buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) begin
        byte_r[i] <= byte_nxt[i];
        cmd_r[i]  <= cmd_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire
